// ----- rtl/core/crcfw_pkg.sv -----
`timescale 1ns / 1ps

package crcfw_pkg;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CRC_TOP     = 8'h80;
    localparam logic [7:0] DUMMY_BYTE  = 8'h00;
    localparam logic [7:0] RETRY_RESET = 8'd10;
    localparam logic [7:0] ACK_RESET   = 8'd1;

    localparam int CFG_IDX_W  = 2;
    localparam int FRAME_LEN  = 7;
    localparam int BEAT_W     = $clog2(FRAME_LEN);

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_MASK    = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_STATUS = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_FAIL   = 2'd2,
        KIND_IGNORE = 2'd3
    } out_kind_t;

    // Positions of the frame bytes within a burst.
    localparam logic [BEAT_W-1:0] BEAT_ADDR  = BEAT_W'(0);
    localparam logic [BEAT_W-1:0] BEAT_VAL3  = BEAT_W'(1);
    localparam logic [BEAT_W-1:0] BEAT_VAL2  = BEAT_W'(2);
    localparam logic [BEAT_W-1:0] BEAT_VAL1  = BEAT_W'(3);
    localparam logic [BEAT_W-1:0] BEAT_VAL0  = BEAT_W'(4);
    localparam logic [BEAT_W-1:0] BEAT_CRC   = BEAT_W'(5);
    localparam logic [BEAT_W-1:0] BEAT_DUMMY = BEAT_W'(FRAME_LEN - 1);

    typedef struct packed {
        logic        start;
        out_kind_t   kind;
        logic        load;
        logic [7:0]  addr;
        logic [31:0] value;
    } seq_cmd_t;

    typedef struct packed {
        logic busy;
        logic final_beat;
    } seq_stat_t;

    // One byte of the CRC-8 (poly 0x07, MSB first).
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/crcfw_frame_seq.sv -----
`timescale 1ns / 1ps

module crcfw_frame_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  crcfw_pkg::seq_cmd_t cmd,
    output crcfw_pkg::seq_stat_t stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [1:0]          kind,
    output logic [7:0]          tx_byte,
    output logic                last
);
    import crcfw_pkg::*;

    logic              busy_reg, busy_next;
    logic [BEAT_W-1:0] beat_reg, beat_next;
    out_kind_t         kind_reg, kind_next;
    logic [7:0]        crc_reg, crc_next;
    logic [7:0]        addr_reg, addr_next;
    logic [31:0]       value_reg, value_next;
    logic              is_frame;
    logic              final_beat;
    logic              take;
    logic [7:0]        byte_sel;

    assign is_frame   = (kind_reg == KIND_BYTE);
    assign final_beat = !is_frame || (beat_reg == BEAT_DUMMY);
    assign take       = busy_reg && m_tready;

    always_comb begin
        unique case (beat_reg)
            BEAT_ADDR:  byte_sel = addr_reg;
            BEAT_VAL3:  byte_sel = value_reg[31:24];
            BEAT_VAL2:  byte_sel = value_reg[23:16];
            BEAT_VAL1:  byte_sel = value_reg[15:8];
            BEAT_VAL0:  byte_sel = value_reg[7:0];
            BEAT_CRC:   byte_sel = crc_reg;
            default:    byte_sel = DUMMY_BYTE;
        endcase
    end

    assign m_tvalid        = busy_reg;
    assign kind            = kind_reg;
    assign tx_byte         = is_frame ? byte_sel : 8'h00;
    assign last            = is_frame && (beat_reg == BEAT_DUMMY);
    assign stat.busy       = busy_reg;
    assign stat.final_beat = final_beat;

    always_comb begin
        busy_next  = busy_reg;
        beat_next  = beat_reg;
        kind_next  = kind_reg;
        crc_next   = crc_reg;
        addr_next  = addr_reg;
        value_next = value_reg;
        if (take && !final_beat) begin
            beat_next = beat_reg + BEAT_W'(1);
            // The check byte is built up as the five frame bytes leave, so a
            // resend produces the same value again.
            crc_next  = crc8_byte(crc_reg, byte_sel);
        end else if (take) begin
            busy_next = 1'b0;
        end
        if (cmd.start) begin
            busy_next = 1'b1;
            beat_next = BEAT_ADDR;
            kind_next = cmd.kind;
            crc_next  = 8'h00;
            if (cmd.load) begin
                addr_next  = cmd.addr;
                value_next = cmd.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= BEAT_ADDR;
            kind_reg <= KIND_IGNORE;
        end else begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
            kind_reg <= kind_next;
        end
        crc_reg   <= crc_next;
        addr_reg  <= addr_next;
        value_reg <= value_next;
    end

endmodule

// ----- rtl/core/crc_framed_register_write_master.sv -----
`timescale 1ns / 1ps

// Register-write master with CRC-8 framing and bounded retries. A write request
// produces seven beats on the master side (address, value MSB first, CRC-8
// with polynomial 0x07, and a dummy zero byte marked by tlast); a status beat
// produces either a resend (seven beats), an acknowledge or a failure beat;
// clears and out-of-place requests produce one beat of kind "ignored". Beats
// leave one per cycle while m_tready is high. The output sequencer holds one
// result at a time; the next request is taken in the same cycle that the final
// beat of the previous result is taken, so s_tready depends combinationally on
// m_tready. The counter and status fields of every beat show the state after
// the request that caused it.
module crc_framed_register_write_master (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,  // write_addr, reg_value, status_in
    input  logic [1:0]                     s_tuser,  // req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tx_byte, last_status, nack_total, failure_total, attempt_index
    output logic [87:0]                    m_tdata,
    output logic [1:0]                     m_tuser,  // out_kind
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [crcfw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import crcfw_pkg::*;

    logic [7:0]  retry_limit_reg, ack_mask_reg;
    logic        await_reg, await_next;
    logic [7:0]  attempt_reg, attempt_next;
    logic [7:0]  status_reg, status_next;
    logic [31:0] nack_reg, nack_next;
    logic [31:0] fail_reg, fail_next;

    seq_cmd_t    cmd;
    seq_stat_t   stat;
    logic        s_take;
    logic [8:0]  attempt_inc;
    req_type_t   req;
    logic [7:0]  in_addr, in_status;
    logic [31:0] in_value;
    logic [7:0]  tx_byte;

    assign req       = req_type_t'(s_tuser);
    assign in_addr   = s_tdata[7:0];
    assign in_value  = s_tdata[39:8];
    assign in_status = s_tdata[47:40];

    assign s_tready    = !stat.busy || (m_tready && stat.final_beat);
    assign s_take      = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;
    assign attempt_inc = {1'b0, attempt_reg} + 9'd1;

    always_comb begin
        await_next   = await_reg;
        attempt_next = attempt_reg;
        status_next  = status_reg;
        nack_next    = nack_reg;
        fail_next    = fail_reg;
        cmd.start    = s_take;
        cmd.kind     = KIND_IGNORE;
        cmd.load     = 1'b0;
        cmd.addr     = in_addr;
        cmd.value    = in_value;
        if (s_take) begin
            unique case (req)
                REQ_WRITE: begin
                    if (!await_reg) begin
                        await_next   = 1'b1;
                        attempt_next = 8'd0;
                        cmd.kind     = KIND_BYTE;
                        cmd.load     = 1'b1;
                    end
                end
                REQ_STATUS: begin
                    if (await_reg) begin
                        status_next = in_status;
                        if ((in_status & ack_mask_reg) != 8'h00) begin
                            await_next = 1'b0;
                            cmd.kind   = KIND_ACK;
                        end else begin
                            nack_next = nack_reg + 32'd1;
                            if (attempt_inc >= {1'b0, retry_limit_reg}) begin
                                fail_next  = fail_reg + 32'd1;
                                await_next = 1'b0;
                                cmd.kind   = KIND_FAIL;
                            end else begin
                                attempt_next = attempt_inc[7:0];
                                cmd.kind     = KIND_BYTE;
                            end
                        end
                    end
                end
                REQ_CLEAR: begin
                    nack_next = 32'd0;
                    fail_next = 32'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= RETRY_RESET;
            ack_mask_reg    <= ACK_RESET;
            await_reg       <= 1'b0;
            attempt_reg     <= 8'd0;
            status_reg      <= 8'd0;
            nack_reg        <= 32'd0;
            fail_reg        <= 32'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data;
                    CFG_ACK_MASK:    ack_mask_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
            await_reg   <= await_next;
            attempt_reg <= attempt_next;
            status_reg  <= status_next;
            nack_reg    <= nack_next;
            fail_reg    <= fail_next;
        end
    end

    crcfw_frame_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .kind     (m_tuser),
        .tx_byte  (tx_byte),
        .last     (m_tlast)
    );

    // Status fields are stable for the whole result: the next request is only
    // taken together with the final beat.
    assign m_tdata = {attempt_reg, fail_reg, nack_reg, status_reg, tx_byte};

endmodule
